@@ hdl/gtcs_pkg.sv @@
// Shared types and constants of the GEMM tile command sequencer.
// No dependencies; imported by every module of the block.
package gtcs_pkg;

    localparam int TILE_SIZE = 8;
    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int ADDR_W    = 32;
    localparam int TSZ_W     = 4;
    localparam int CFG_IDX_W = 3;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_A_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_STRIDE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C_STRIDE = 3'd5;

    // One classified tile: offsets, clipped sizes and flags.
    typedef struct packed {
        logic [DIM_W-1:0] pos_m;
        logic [DIM_W-1:0] pos_k;
        logic [DIM_W-1:0] pos_n;
        logic [TSZ_W-1:0] tile_rows;
        logic [TSZ_W-1:0] tile_depth;
        logic [TSZ_W-1:0] tile_cols;
        logic             clear_acc;
        logic             store_acc;
        logic             job_last;
    } tile_cmd_t;

endpackage

@@ hdl/gtcs_front.sv @@
// Front end: holds the job dimensions and the m/n/k tile walk, and turns
// each accepted request into at most one tile command. Depends on gtcs_pkg.
module gtcs_front
    import gtcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             op,
    input  logic [DIM_W-1:0] rows_m,
    input  logic [DIM_W-1:0] depth_k,
    input  logic [DIM_W-1:0] cols_n,
    output logic             push,
    output tile_cmd_t        cmd
);

    logic             job_active_reg, job_active_next;
    logic [DIM_W-1:0] dim_m_reg, dim_m_next;
    logic [DIM_W-1:0] dim_k_reg, dim_k_next;
    logic [DIM_W-1:0] dim_n_reg, dim_n_next;
    logic [DIM_W-1:0] pos_m_reg, pos_m_next;
    logic [DIM_W-1:0] pos_k_reg, pos_k_next;
    logic [DIM_W-1:0] pos_n_reg, pos_n_next;

    logic [DIM_W-1:0] dm, dk, dn, pm, pk, pn;
    logic             act;
    logic [DIM_W:0]   nm, nk, nn;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if ({1'b0, v} > (DIM_W+1)'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    function automatic logic [TSZ_W-1:0] clip_tile(input logic [DIM_W-1:0] d,
                                                   input logic [DIM_W-1:0] p);
        logic [DIM_W-1:0] rem;
        logic [DIM_W-1:0] sz;
        rem = d - p;
        sz  = ({1'b0, rem} < (DIM_W+1)'(TILE_SIZE)) ? rem : DIM_W'(TILE_SIZE);
        return sz[TSZ_W-1:0];
    endfunction

    always_comb
    begin
        if (op == OP_START)
        begin
            dm  = clamp_dim(rows_m);
            dk  = clamp_dim(depth_k);
            dn  = clamp_dim(cols_n);
            pm  = '0;
            pk  = '0;
            pn  = '0;
            act = (dm != '0) && (dk != '0) && (dn != '0);
        end
        else
        begin
            dm  = dim_m_reg;
            dk  = dim_k_reg;
            dn  = dim_n_reg;
            pm  = pos_m_reg;
            pk  = pos_k_reg;
            pn  = pos_n_reg;
            act = job_active_reg;
        end

        nm = {1'b0, pm} + (DIM_W+1)'(TILE_SIZE);
        nk = {1'b0, pk} + (DIM_W+1)'(TILE_SIZE);
        nn = {1'b0, pn} + (DIM_W+1)'(TILE_SIZE);

        cmd.pos_m      = pm;
        cmd.pos_k      = pk;
        cmd.pos_n      = pn;
        cmd.tile_rows  = clip_tile(dm, pm);
        cmd.tile_depth = clip_tile(dk, pk);
        cmd.tile_cols  = clip_tile(dn, pn);
        cmd.clear_acc  = (pk == '0);
        cmd.store_acc  = (nk >= {1'b0, dk});
        cmd.job_last   = 1'b0;

        dim_m_next      = dim_m_reg;
        dim_k_next      = dim_k_reg;
        dim_n_next      = dim_n_reg;
        pos_m_next      = pos_m_reg;
        pos_k_next      = pos_k_reg;
        pos_n_next      = pos_n_reg;
        job_active_next = job_active_reg;

        if (accept)
        begin
            dim_m_next      = dm;
            dim_k_next      = dk;
            dim_n_next      = dn;
            pos_m_next      = pm;
            pos_k_next      = pk;
            pos_n_next      = pn;
            job_active_next = act;
            if (act)
            begin
                // Advance k first, then n, then m; the job ends after the last m row.
                if (nk < {1'b0, dk})
                    pos_k_next = nk[DIM_W-1:0];
                else
                begin
                    pos_k_next = '0;
                    if (nn < {1'b0, dn})
                        pos_n_next = nn[DIM_W-1:0];
                    else
                    begin
                        pos_n_next = '0;
                        if (nm < {1'b0, dm})
                            pos_m_next = nm[DIM_W-1:0];
                        else
                        begin
                            pos_m_next      = '0;
                            job_active_next = 1'b0;
                            cmd.job_last    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign push = accept && act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_active_reg <= 1'b0;
            dim_m_reg      <= '0;
            dim_k_reg      <= '0;
            dim_n_reg      <= '0;
            pos_m_reg      <= '0;
            pos_k_reg      <= '0;
            pos_n_reg      <= '0;
        end
        else
        begin
            job_active_reg <= job_active_next;
            dim_m_reg      <= dim_m_next;
            dim_k_reg      <= dim_k_next;
            dim_n_reg      <= dim_n_next;
            pos_m_reg      <= pos_m_next;
            pos_k_reg      <= pos_k_next;
            pos_n_reg      <= pos_n_next;
        end
    end

endmodule

@@ hdl/gtcs_queue.sv @@
// Small command queue between the front end and the address back end.
// Depends on gtcs_pkg for the command type.
module gtcs_queue
    import gtcs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tile_cmd_t push_cmd,
    input  logic      pop,
    output logic      not_full,
    output logic      not_empty,
    output tile_cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tile_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/gtcs_back.sv @@
// Back end: holds the base and pitch registers and forms the three tile
// addresses in two stages (products, then sums). Depends on gtcs_pkg.
module gtcs_back
    import gtcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata,
    input  logic                 cmd_valid,
    input  tile_cmd_t            cmd,
    output logic                 cmd_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    a_addr,
    output logic [ADDR_W-1:0]    b_addr,
    output logic [ADDR_W-1:0]    c_addr,
    output logic [TSZ_W-1:0]     tile_rows,
    output logic [TSZ_W-1:0]     tile_depth,
    output logic [TSZ_W-1:0]     tile_cols,
    output logic                 clear_acc,
    output logic                 store_acc,
    output logic                 job_last
);

    localparam int PROD_W = 2 * DIM_W;

    logic [ADDR_W-1:0] a_base_reg, b_base_reg, c_base_reg;
    logic [DIM_W-1:0]  a_stride_reg, b_stride_reg, c_stride_reg;

    // Stage 1: products and the command that goes with them.
    logic              s1_valid_reg;
    tile_cmd_t         s1_cmd_reg;
    logic [PROD_W-1:0] s1_ma_reg, s1_kb_reg, s1_mc_reg;

    // Stage 2: the output register.
    logic              s2_valid_reg;
    logic [ADDR_W-1:0] a_addr_reg, b_addr_reg, c_addr_reg;
    tile_cmd_t         s2_cmd_reg;

    logic              s2_load, s1_load;
    logic [ADDR_W-1:0] c_elem;

    assign s2_load = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign s1_load = !s1_valid_reg || s2_load;
    assign cmd_pop = cmd_valid && s1_load;
    assign c_elem  = ADDR_W'(s1_mc_reg) + ADDR_W'(s1_cmd_reg.pos_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_base_reg   <= '0;
            b_base_reg   <= '0;
            c_base_reg   <= '0;
            a_stride_reg <= '0;
            b_stride_reg <= '0;
            c_stride_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_A_BASE:   a_base_reg   <= cfg_wdata;
                CFG_B_BASE:   b_base_reg   <= cfg_wdata;
                CFG_C_BASE:   c_base_reg   <= cfg_wdata;
                CFG_A_STRIDE: a_stride_reg <= cfg_wdata[DIM_W-1:0];
                CFG_B_STRIDE: b_stride_reg <= cfg_wdata[DIM_W-1:0];
                CFG_C_STRIDE: c_stride_reg <= cfg_wdata[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= cmd_valid;
            if (s2_load)
                s2_valid_reg <= 1'b1;
            else if (out_ready)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_cmd_reg <= cmd;
            s1_ma_reg  <= cmd.pos_m * a_stride_reg;
            s1_kb_reg  <= cmd.pos_k * b_stride_reg;
            s1_mc_reg  <= cmd.pos_m * c_stride_reg;
        end
        if (s2_load)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            a_addr_reg <= a_base_reg + ADDR_W'(s1_ma_reg) + ADDR_W'(s1_cmd_reg.pos_k);
            b_addr_reg <= b_base_reg + ADDR_W'(s1_kb_reg) + ADDR_W'(s1_cmd_reg.pos_n);
            c_addr_reg <= c_base_reg + {c_elem[ADDR_W-3:0], 2'b00};
        end
    end

    assign out_valid  = s2_valid_reg;
    assign a_addr     = a_addr_reg;
    assign b_addr     = b_addr_reg;
    assign c_addr     = c_addr_reg;
    assign tile_rows  = s2_cmd_reg.tile_rows;
    assign tile_depth = s2_cmd_reg.tile_depth;
    assign tile_cols  = s2_cmd_reg.tile_cols;
    assign clear_acc  = s2_cmd_reg.clear_acc;
    assign store_acc  = s2_cmd_reg.store_acc;
    assign job_last   = s2_cmd_reg.job_last;

endmodule

@@ hdl/gemm_tile_command_sequencer.sv @@
// Top level of the GEMM tile command sequencer: front end, command queue
// and address back end. Depends on gtcs_pkg, gtcs_front, gtcs_queue, gtcs_back.
//
//  Channel   Direction  Handshake          Carries
//  s_*       in         s_tvalid/s_tready  a start or next-tile request
//  m_*       out        m_tvalid/m_tready  one tile command
//  cfg_*     in         cfg_we             base and pitch register writes
//
// One request is accepted per cycle while the command queue has room; a
// tile command passes through the queue entry, the product stage and the sum
// stage before it leaves, and the sustained rate is one command per cycle while
// m_tready is high, set by the loop-counter update in the front end. Reset clears
// the job state, the queue pointers, the pipeline valid bits and the base and
// pitch registers; the data registers need no reset. A stall on m_tready backs
// up the back end and then fills the queue; s_tready falls only when the queue
// is full. Requests that produce no command just update state.
module gemm_tile_command_sequencer
    import gtcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Request stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // rows_m[12:0], depth_k[25:13], cols_n[38:26], pad
    input  logic                 s_tuser,   // op: 0 start, 1 next tile
    // Tile command stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [111:0]         m_tdata,   // a_addr, b_addr, c_addr, tile_rows,
                                            // tile_depth, tile_cols, pad
    output logic [1:0]           m_tuser,   // clear_acc, store_acc
    output logic                 m_tlast,   // job_last
    // Configuration writes.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_wdata
);

    logic             accept;
    logic             push;
    tile_cmd_t        front_cmd;
    logic             q_not_full, q_not_empty, q_pop;
    tile_cmd_t        head_cmd;
    logic [ADDR_W-1:0] a_addr, b_addr, c_addr;
    logic [TSZ_W-1:0] tile_rows, tile_depth, tile_cols;

    // A request is taken whenever the queue can absorb the command it may cause.
    assign s_tready = q_not_full;
    assign accept   = s_tvalid && s_tready;

    gtcs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (s_tuser),
        .rows_m  (s_tdata[12:0]),
        .depth_k (s_tdata[25:13]),
        .cols_n  (s_tdata[38:26]),
        .push    (push),
        .cmd     (front_cmd)
    );

    gtcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    gtcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (q_not_empty),
        .cmd        (head_cmd),
        .cmd_pop    (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .a_addr     (a_addr),
        .b_addr     (b_addr),
        .c_addr     (c_addr),
        .tile_rows  (tile_rows),
        .tile_depth (tile_depth),
        .tile_cols  (tile_cols),
        .clear_acc  (m_tuser[0]),
        .store_acc  (m_tuser[1]),
        .job_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, tile_cols, tile_depth, tile_rows, c_addr, b_addr, a_addr};

endmodule

@@ bench/gemm_tile_command_sequencer_test.sv @@
// Self-checking bench for the GEMM tile command sequencer: a directed table, then
// random jobs in several register settings, checked against an in-bench predictor.
// Depends on gtcs_pkg and gemm_tile_command_sequencer.
module gemm_tile_command_sequencer_test
    import gtcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // How a request of the directed table is checked. The command it should
    // cause is either worked out by the predictor or typed into the row, a
    // request can be declared to cause nothing, and a row can instead hold a
    // register write.
    typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_TYPED, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        logic [31:0] a_addr;
        logic [31:0] b_addr;
        logic [31:0] c_addr;
        logic [3:0]  rows;
        logic [3:0]  depth;
        logic [3:0]  cols;
        logic        clear;
        logic        store;
        logic        last;
    } tile_command_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  op;
        logic [DIM_W-1:0]      m;
        logic [DIM_W-1:0]      k;
        logic [DIM_W-1:0]      n;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [ADDR_W-1:0]     reg_val;
        tile_command_t         cmd;
    } table_row_t;

    localparam tile_command_t NO_CMD = '0;

    // Cycles a request can still be inside the block after the last command
    // came out: the back-end pipeline stages plus the command queue, with margin.
    localparam int SETTLE_CYCLES      = 12;
    localparam int DRAIN_LIMIT        = 4000;
    localparam int NUM_PHASES         = 10;
    localparam int REQUESTS_PER_PHASE = 145;

    // Directed table. All registers are zero after reset, so the addresses of
    // the first rows reduce to the k and n offsets and can be typed in.
    localparam int SCRIPT_LEN = 28;
    localparam table_row_t SCRIPT [SCRIPT_LEN] = '{
        // Next request while no job is open: ignored.
        '{ROW_QUIET, OP_NEXT, 13'd8191, 13'd8191, 13'd8191, CFG_A_BASE, 32'd0, NO_CMD},
        // Smallest job: a single tile that is first, last and stored at once.
        '{ROW_TYPED, OP_START, 13'd1, 13'd1, 13'd1, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd0, 32'd0, 4'd1, 4'd1, 4'd1, 1'b1, 1'b1, 1'b1}},
        '{ROW_QUIET, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0, NO_CMD},
        // A zero dimension closes the job without a command.
        '{ROW_QUIET, OP_START, 13'd0, 13'd5, 13'd5, CFG_A_BASE, 32'd0, NO_CMD},
        '{ROW_QUIET, OP_NEXT, 13'd1, 13'd1, 13'd1, CFG_A_BASE, 32'd0, NO_CMD},
        // Oversized dimensions saturate to the largest legal size.
        '{ROW_TYPED, OP_START, 13'd8191, 13'd8191, 13'd8191, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd0, 32'd0, 4'd8, 4'd8, 4'd8, 1'b1, 1'b0, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd8, 32'd0, 32'd0, 4'd8, 4'd8, 4'd8, 1'b0, 1'b0, 1'b0}},
        // A start in the middle of a job abandons it; depth one stores at once.
        '{ROW_TYPED, OP_START, 13'd4097, 13'd1, 13'd8191, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd0, 32'd0, 4'd8, 4'd1, 4'd8, 1'b1, 1'b1, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd8, 32'd32, 4'd8, 4'd1, 4'd8, 1'b1, 1'b1, 1'b0}},
        // A 9x9x9 job walks all eight tiles, k inner, n middle, m outer.
        '{ROW_TYPED, OP_START, 13'd9, 13'd9, 13'd9, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd0, 32'd0, 4'd8, 4'd8, 4'd8, 1'b1, 1'b0, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd8, 32'd0, 32'd0, 4'd8, 4'd1, 4'd8, 1'b0, 1'b1, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd8, 32'd32, 4'd8, 4'd8, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd8, 32'd8, 32'd32, 4'd8, 4'd1, 4'd1, 1'b0, 1'b1, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd0, 32'd0, 4'd1, 4'd8, 4'd8, 1'b1, 1'b0, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd8, 32'd0, 32'd0, 4'd1, 4'd1, 4'd8, 1'b0, 1'b1, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd0, 32'd8, 32'd32, 4'd1, 4'd8, 4'd1, 1'b1, 1'b0, 1'b0}},
        '{ROW_TYPED, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0,
          '{32'd8, 32'd8, 32'd32, 4'd1, 4'd1, 4'd1, 1'b0, 1'b1, 1'b1}},
        '{ROW_QUIET, OP_NEXT, 13'd4096, 13'd4096, 13'd4096, CFG_A_BASE, 32'd0, NO_CMD},
        // Bases near the top of the address space and pitches of 4096,
        // so that each address wraps once an offset it uses moves off zero.
        '{ROW_CONFIG, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'hFFFF_FFF8, NO_CMD},
        '{ROW_CONFIG, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_B_BASE, 32'hFFFF_FFFF, NO_CMD},
        '{ROW_CONFIG, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_C_BASE, 32'hFFFF_FFFC, NO_CMD},
        '{ROW_CONFIG, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_STRIDE, 32'd4096, NO_CMD},
        '{ROW_CONFIG, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_B_STRIDE, 32'd4096, NO_CMD},
        '{ROW_CONFIG, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_C_STRIDE, 32'd4096, NO_CMD},
        '{ROW_PREDICT, OP_START, 13'd9, 13'd16, 13'd8, CFG_A_BASE, 32'd0, NO_CMD},
        '{ROW_PREDICT, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0, NO_CMD},
        '{ROW_PREDICT, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0, NO_CMD},
        '{ROW_PREDICT, OP_NEXT, 13'd0, 13'd0, 13'd0, CFG_A_BASE, 32'd0, NO_CMD}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;   // rows_m, depth_k, cols_n, pad
    logic                 s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [111:0]         m_tdata;   // a_addr, b_addr, c_addr, tile_rows, tile_depth,
                                     // tile_cols, pad
    logic [1:0]           m_tuser;   // clear_acc, store_acc
    logic                 m_tlast;   // job_last
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_wdata;

    // Shadow of the block: registers, job dimensions and next tile offsets.
    logic [31:0]      base_a = '0, base_b = '0, base_c = '0;
    logic [DIM_W-1:0] pitch_a = '0, pitch_b = '0, pitch_c = '0;
    logic             job_open = 1'b0;
    logic [DIM_W-1:0] span_m = '0, span_k = '0, span_n = '0;
    logic [DIM_W-1:0] at_m = '0, at_k = '0, at_n = '0;

    // Commands still owed by the block, oldest first.
    tile_command_t owed_commands [$];

    // The kind and typed command that travel with the request on the bus.
    row_kind_t     req_kind = ROW_PREDICT;
    tile_command_t req_cmd  = NO_CMD;

    // When set, the request side waits a random number of cycles per request.
    bit            tx_busy = 1'b1;

    int            errors = 0;
    int            useful_requests = 0;
    tile_command_t predicted, want, got;
    logic          produced;

    gemm_tile_command_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A dimension above the largest legal size is cut down to it.
    function automatic logic [DIM_W-1:0] saturate_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // Size of a tile along one axis: what is left of the axis, at most a tile.
    function automatic logic [3:0] tile_extent(input logic [DIM_W-1:0] span,
                                               input logic [DIM_W-1:0] at);
        int unsigned rest;
        rest = span - at;
        return (rest < TILE_SIZE) ? 4'(rest) : 4'(TILE_SIZE);
    endfunction

    // Applies one request to the shadow state. Returns 1 and the tile command
    // when the request causes one; the offsets then step k, then n, then m.
    function automatic logic issue_tile(input logic op, input logic [DIM_W-1:0] rm,
                                        input logic [DIM_W-1:0] rk,
                                        input logic [DIM_W-1:0] rn,
                                        output tile_command_t cmd);
        int unsigned nk, nn, nm;
        cmd = NO_CMD;
        if (op == OP_START)
        begin
            span_m   = saturate_dim(rm);
            span_k   = saturate_dim(rk);
            span_n   = saturate_dim(rn);
            at_m     = '0;
            at_k     = '0;
            at_n     = '0;
            job_open = (span_m != 0) && (span_k != 0) && (span_n != 0);
        end
        if (!job_open)
            return 1'b0;
        cmd.a_addr = base_a + at_m * pitch_a + at_k;
        cmd.b_addr = base_b + at_k * pitch_b + at_n;
        cmd.c_addr = base_c + 32'd4 * (at_m * pitch_c + at_n);
        cmd.rows   = tile_extent(span_m, at_m);
        cmd.depth  = tile_extent(span_k, at_k);
        cmd.cols   = tile_extent(span_n, at_n);
        cmd.clear  = (at_k == 0);
        nk = at_k + TILE_SIZE;
        nn = at_n + TILE_SIZE;
        nm = at_m + TILE_SIZE;
        cmd.store  = (nk >= span_k);
        if (nk < span_k)
            at_k = DIM_W'(nk);
        else
        begin
            at_k = '0;
            if (nn < span_n)
                at_n = DIM_W'(nn);
            else
            begin
                at_n = '0;
                if (nm < span_m)
                    at_m = DIM_W'(nm);
                else
                begin
                    at_m     = '0;
                    job_open = 1'b0;
                    cmd.last = 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic longint tile_count(input logic [DIM_W-1:0] m,
                                          input logic [DIM_W-1:0] k,
                                          input logic [DIM_W-1:0] n);
        longint tm, tk, tn;
        tm = (longint'(saturate_dim(m)) + TILE_SIZE - 1) / TILE_SIZE;
        tk = (longint'(saturate_dim(k)) + TILE_SIZE - 1) / TILE_SIZE;
        tn = (longint'(saturate_dim(n)) + TILE_SIZE - 1) / TILE_SIZE;
        return tm * tk * tn;
    endfunction

    // Mostly sizes of one to three tiles, now and then up to five.
    function automatic logic [DIM_W-1:0] small_dim();
        return DIM_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 17));
    endfunction

    // Sizes at the tile boundaries, at the legal limit and above it.
    function automatic logic [DIM_W-1:0] edge_dim();
        case ($urandom_range(0, 9))
            0:       return 13'd1;
            1:       return 13'd7;
            2:       return 13'd8;
            3:       return 13'd9;
            4:       return 13'd16;
            5:       return 13'd17;
            6:       return 13'd4095;
            7:       return 13'd4096;
            8:       return DIM_W'($urandom_range(4097, 8191));
            default: return DIM_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // Register value for one phase: the first two phases hold the extremes,
    // later ones mix zero, all ones, upper junk on the pitches and random values.
    function automatic logic [31:0] draw_setting(input bit pitch, input int phase);
        if (phase == 0)
            return pitch ? 32'd4096 : 32'hFFFF_FFFF;
        if (phase == 1)
            return 32'd0;
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return pitch ? 32'd4096 : 32'hFFFF_FFFF;
            2:       return pitch ? $urandom : 32'h8000_0000;
            default: return pitch ? $urandom_range(0, 4096) : $urandom;
        endcase
    endfunction

    task automatic report_field(input string field, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, exp_val, act_val);
        end
    endtask

    // Requests and commands are observed at the rising edge, where the
    // handshake completes. The shadow registers follow the write port here too.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_A_BASE:   base_a  = cfg_wdata;
                    CFG_B_BASE:   base_b  = cfg_wdata;
                    CFG_C_BASE:   base_c  = cfg_wdata;
                    CFG_A_STRIDE: pitch_a = cfg_wdata[DIM_W-1:0];
                    CFG_B_STRIDE: pitch_b = cfg_wdata[DIM_W-1:0];
                    CFG_C_STRIDE: pitch_c = cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                produced = issue_tile(s_tuser, s_tdata[12:0], s_tdata[25:13],
                                      s_tdata[38:26], predicted);
                if (s_tuser == OP_START || produced)
                    useful_requests++;
                // A typed row stands in for the predictor; a quiet row owes nothing.
                case (req_kind)
                    ROW_TYPED: owed_commands.push_back(req_cmd);
                    ROW_QUIET: ;
                    default:   if (produced) owed_commands.push_back(predicted);
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.a_addr = m_tdata[31:0];
                got.b_addr = m_tdata[63:32];
                got.c_addr = m_tdata[95:64];
                got.rows   = m_tdata[99:96];
                got.depth  = m_tdata[103:100];
                got.cols   = m_tdata[107:104];
                got.clear  = m_tuser[0];
                got.store  = m_tuser[1];
                got.last   = m_tlast;
                if (owed_commands.size() == 0)
                begin
                    errors++;
                    $display("%0t: tile command with none expected, got %h", $time, got);
                end
                else
                begin
                    want = owed_commands.pop_front();
                    report_field("a_addr", want.a_addr, got.a_addr);
                    report_field("b_addr", want.b_addr, got.b_addr);
                    report_field("c_addr", want.c_addr, got.c_addr);
                    report_field("tile_rows", 32'(want.rows), 32'(got.rows));
                    report_field("tile_depth", 32'(want.depth), 32'(got.depth));
                    report_field("tile_cols", 32'(want.cols), 32'(got.cols));
                    report_field("clear_acc", 32'(want.clear), 32'(got.clear));
                    report_field("store_acc", 32'(want.store), 32'(got.store));
                    report_field("job_last", 32'(want.last), 32'(got.last));
                end
            end
        end
    end

    // Offers one request after a random gap and returns at the falling edge
    // after it was taken. Valid stays high, so back-to-back requests are not
    // broken up; only a gap lowers it.
    task automatic send_request(input logic op, input logic [DIM_W-1:0] rm,
                                input logic [DIM_W-1:0] rk, input logic [DIM_W-1:0] rn,
                                input row_kind_t kind, input tile_command_t cmd);
        int gap;
        gap = tx_busy ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {1'b0, rn, rk, rm};
        req_kind = kind;
        req_cmd  = cmd;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // The dimension fields of a next request carry junk; the block ignores them.
    task automatic send_next();
        send_request(OP_NEXT, DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                     ROW_PREDICT, NO_CMD);
    endtask

    // Waits until every owed command has come out, then lets the pipeline
    // settle so that requests without a command have finished too.
    task automatic wait_for_drain();
        int waited;
        waited   = 0;
        s_tvalid = 1'b0;
        while (owed_commands.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (owed_commands.size() != 0)
        begin
            errors++;
            $display("%0t: %0d tile commands never came, expected next %h",
                     $time, owed_commands.size(), owed_commands[0]);
            owed_commands.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // One random job. Most are complete jobs of small size, followed at times
    // by a stray next request; the rest are abandoned jobs, zero sizes, edge
    // sizes and plain noise.
    task automatic run_job();
        int            pick;
        longint        nexts;
        logic [DIM_W-1:0] m, k, n;
        int            zero_mask;
        pick    = $urandom_range(0, 99);
        tx_busy = ($urandom_range(0, 3) != 0);
        if (pick >= 95)
        begin
            repeat ($urandom_range(1, 4))
                send_request(1'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                             DIM_W'($urandom), ROW_PREDICT, NO_CMD);
            return;
        end
        if (pick < 70)
        begin
            m     = small_dim();
            k     = small_dim();
            n     = small_dim();
            nexts = tile_count(m, k, n) - 1;
        end
        else if (pick < 80)
        begin
            m     = edge_dim();
            k     = edge_dim();
            n     = edge_dim();
            nexts = $urandom_range(0, 5);
        end
        else if (pick < 88)
        begin
            zero_mask = $urandom_range(1, 7);
            m     = zero_mask[0] ? '0 : edge_dim();
            k     = zero_mask[1] ? '0 : edge_dim();
            n     = zero_mask[2] ? '0 : edge_dim();
            nexts = 1;
        end
        else
        begin
            m     = edge_dim();
            k     = edge_dim();
            n     = edge_dim();
            nexts = tile_count(m, k, n);
            nexts = (nexts <= 64) ? nexts - 1 : $urandom_range(1, 12);
        end
        send_request(OP_START, m, k, n, ROW_PREDICT, NO_CMD);
        repeat (nexts) send_next();
        if (pick < 70 && $urandom_range(0, 4) == 0)
            send_next();
    endtask

    // Command side: per command a random stall, with stretches of full speed.
    initial
    begin
        int stall;
        int rx_burst;
        bit rx_busy;
        rx_burst = 0;
        rx_busy  = 1'b0;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_burst == 0)
            begin
                rx_burst = $urandom_range(10, 60);
                rx_busy  = ($urandom_range(0, 3) != 0);
            end
            rx_burst--;
            stall = rx_busy ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Request side and overall flow: reset, directed table, then phases of
    // random jobs, each phase under a fresh set of registers.
    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_START;
        cfg_we    = 1'b0;
        cfg_index = CFG_A_BASE;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == ROW_CONFIG)
            begin
                wait_for_drain();
                write_register(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
            end
            else
                send_request(SCRIPT[i].op, SCRIPT[i].m, SCRIPT[i].k, SCRIPT[i].n,
                             SCRIPT[i].kind, SCRIPT[i].cmd);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_for_drain();
            write_register(CFG_A_BASE, draw_setting(1'b0, phase));
            write_register(CFG_B_BASE, draw_setting(1'b0, phase));
            write_register(CFG_C_BASE, draw_setting(1'b0, phase));
            write_register(CFG_A_STRIDE, draw_setting(1'b1, phase));
            write_register(CFG_B_STRIDE, draw_setting(1'b1, phase));
            write_register(CFG_C_STRIDE, draw_setting(1'b1, phase));
            while (useful_requests < (phase + 1) * REQUESTS_PER_PHASE)
                run_job();
        end

        wait_for_drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
